// ===== sv/ppd_pkg.sv =====
// ppd_pkg: shared types, constants and register indexes of the preamble/postamble deframer
// no dependencies; compiled first

package ppd_pkg;

   localparam int MAX_FRAME_LEN_DEF = 256;
   localparam int MARKER_LEN_DEF    = 6;

   localparam int BYTE_W     = 8;
   localparam int MINLEN_W   = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [MINLEN_W-1:0] MIN_FRAME_LEN_RST = MINLEN_W'(26);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PREAMBLE  = 2'd0,
      CSR_POSTAMBLE = 2'd1,
      CSR_MIN_LEN   = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_HUNT    = 5'b00001,
      PH_LEN     = 5'b00010,
      PH_PAYLOAD = 5'b00100,
      PH_POST    = 5'b01000,
      PH_TAIL    = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      V_NONE = 3'b001,
      V_OK   = 3'b010,
      V_BAD  = 3'b100
   } verdict_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   preamble_value;
      logic [BYTE_W-1:0]   postamble_value;
      logic [MINLEN_W-1:0] min_frame_len;
   } cfg_type;

   typedef struct packed {
      logic              item_type;
      logic [BYTE_W-1:0] payload_byte;
      logic              accepted;
      logic [BYTE_W-1:0] message_len;
      logic              last;
   } rsp_type;

endpackage

// ===== sv/ppd_if.sv =====
// ppd_if: word channels of the deframer (input bytes, results, register writes)
// depends on ppd_pkg

interface ppd_req_if;
   import ppd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              end_of_frame;
   modport source (output valid, rx_byte, end_of_frame, input ready);
   modport sink (input valid, rx_byte, end_of_frame, output ready);
endinterface

interface ppd_rsp_if;
   import ppd_pkg::*;
   logic              valid;
   logic              ready;
   logic              item_type;
   logic [BYTE_W-1:0] payload_byte;
   logic              accepted;
   logic [BYTE_W-1:0] message_len;
   logic              last;
   modport source (output valid, item_type, payload_byte, accepted, message_len, last,
                   input ready);
   modport sink (input valid, item_type, payload_byte, accepted, message_len, last,
                 output ready);
endinterface

interface ppd_csr_if;
   import ppd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/ppd_csr_regs.sv =====
// ppd_csr_regs: configuration registers of the deframer
// depends on ppd_pkg

module ppd_csr_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [ppd_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [ppd_pkg::CSR_DATA_W-1:0] wr_data,
   output ppd_pkg::cfg_type               cfg
);
   import ppd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(wr_index))
            CSR_PREAMBLE:  cfg_in.preamble_value  = wr_data[BYTE_W-1:0];
            CSR_POSTAMBLE: cfg_in.postamble_value = wr_data[BYTE_W-1:0];
            CSR_MIN_LEN:   cfg_in.min_frame_len   = wr_data[MINLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_value  <= '0;
         cfg_ff.postamble_value <= '0;
         cfg_ff.min_frame_len   <= MIN_FRAME_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/ppd_parser.sv =====
// ppd_parser: per-frame phase machine, one byte per enabled cycle, with result decode
// depends on ppd_pkg

module ppd_parser #(
   parameter int MAX_FRAME_LEN = ppd_pkg::MAX_FRAME_LEN_DEF,
   parameter int MARKER_LEN    = ppd_pkg::MARKER_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ppd_pkg::cfg_type           cfg,
   input  logic                       step_en,
   input  logic [ppd_pkg::BYTE_W-1:0] rx_byte,
   input  logic                       end_of_frame,
   output logic                       has_result,
   output ppd_pkg::rsp_type           result
);
   import ppd_pkg::*;

   localparam int POS_W = $clog2(MAX_FRAME_LEN + 1);
   localparam int RUN_W = $clog2(MARKER_LEN + 1);
   localparam int SUM_W = ((POS_W > MINLEN_W) ? POS_W : MINLEN_W) + 1;
   localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_FRAME_LEN);
   localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(MAX_FRAME_LEN);
   localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(MARKER_LEN - 1);

   logic [POS_W-1:0]  pos_ff, pos_in, pos_upd;
   phase_type         phase_ff, phase_in, phase_upd;
   logic [RUN_W-1:0]  run_ff, run_in, run_upd;
   logic [BYTE_W-1:0] len_ff, len_in, len_upd;
   logic [BYTE_W-1:0] remain_ff, remain_in, remain_upd;
   verdict_type       verdict_ff, verdict_in, verdict_upd;
   logic              emit;
   logic              ok;
   logic [SUM_W-1:0]  len_end;
   logic [BYTE_W-1:0] remain_dec;

   assign len_end    = SUM_W'(pos_ff) + SUM_W'(rx_byte);
   assign remain_dec = remain_ff - 1'b1;

   always_comb begin
      pos_upd     = pos_ff;
      phase_upd   = phase_ff;
      run_upd     = run_ff;
      len_upd     = len_ff;
      remain_upd  = remain_ff;
      verdict_upd = verdict_ff;
      emit        = 1'b0;
      if (pos_ff < POS_MAX) begin
         pos_upd = pos_ff + 1'b1;
      end
      if (verdict_ff == V_NONE) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == cfg.preamble_value) begin
                  if (run_ff == RUN_LAST) begin
                     run_upd   = '0;
                     phase_upd = PH_LEN;
                  end else begin
                     run_upd = run_ff + 1'b1;
                  end
               end else begin
                  run_upd = '0;
               end
            end
            PH_LEN: begin
               // zero length or payload running into the frame limit
               if (rx_byte == '0 || len_end >= SUM_MAX) begin
                  verdict_upd = V_BAD;
               end else begin
                  len_upd    = rx_byte;
                  remain_upd = rx_byte - 1'b1;
                  run_upd    = '0;
                  phase_upd  = (rx_byte == BYTE_W'(1)) ? PH_POST : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               emit       = 1'b1;
               remain_upd = remain_dec;
               if (remain_dec == '0) begin
                  phase_upd = PH_POST;
               end
            end
            PH_POST: begin
               if (rx_byte != cfg.postamble_value) begin
                  verdict_upd = V_BAD;
               end else if (run_ff == RUN_LAST) begin
                  run_upd     = '0;
                  phase_upd   = PH_TAIL;
                  verdict_upd = V_OK;
               end else begin
                  run_upd = run_ff + 1'b1;
               end
            end
            default: verdict_upd = V_BAD;
         endcase
      end
   end

   // frame end puts every per-frame register back to its idle value
   always_comb begin
      if (step_en && end_of_frame) begin
         pos_in     = '0;
         phase_in   = PH_HUNT;
         run_in     = '0;
         len_in     = '0;
         remain_in  = '0;
         verdict_in = V_NONE;
      end else if (step_en) begin
         pos_in     = pos_upd;
         phase_in   = phase_upd;
         run_in     = run_upd;
         len_in     = len_upd;
         remain_in  = remain_upd;
         verdict_in = verdict_upd;
      end else begin
         pos_in     = pos_ff;
         phase_in   = phase_ff;
         run_in     = run_ff;
         len_in     = len_ff;
         remain_in  = remain_ff;
         verdict_in = verdict_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         phase_ff   <= PH_HUNT;
         run_ff     <= '0;
         len_ff     <= '0;
         remain_ff  <= '0;
         verdict_ff <= V_NONE;
      end else begin
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         run_ff     <= run_in;
         len_ff     <= len_in;
         remain_ff  <= remain_in;
         verdict_ff <= verdict_in;
      end
   end

   assign ok = (verdict_upd == V_OK)
               && (SUM_W'(pos_upd) >= SUM_W'(cfg.min_frame_len))
               && (SUM_W'(pos_upd) < SUM_MAX);

   // the byte held now would produce a word if it were stepped
   assign has_result = end_of_frame || emit;

   always_comb begin
      if (end_of_frame) begin
         result.item_type    = 1'b1;
         result.payload_byte = '0;
         result.accepted     = ok;
         result.message_len  = ok ? len_upd : '0;
         result.last         = 1'b1;
      end else begin
         result.item_type    = 1'b0;
         result.payload_byte = rx_byte;
         result.accepted     = 1'b0;
         result.message_len  = '0;
         result.last         = 1'b0;
      end
   end

endmodule

// ===== sv/preamble_postamble_deframer_unit.sv =====
// preamble_postamble_deframer_unit: top level of the preamble/postamble deframer
// depends on ppd_pkg, ppd_if, ppd_csr_regs, ppd_parser

// Takes one received frame byte per word on req_if, last byte flagged by end_of_frame.
// It hunts for the first run of MARKER_LEN preamble bytes, reads the length byte L,
// forwards the L-1 payload bytes as words on rsp_if and then checks MARKER_LEN
// postamble bytes. The frame's last byte always yields one verdict word (last = 1)
// carrying accepted and, when accepted, L. Rejected frames may already have emitted
// payload words; the consumer discards them. A byte word is taken every cycle
// (one per clock sustained) unless a result word meets a full, stalled output register.
// Bytes pass the input register; the phase machine then feeds the output register.
// Register writes on csr_if are always ready and must only be issued while idle.

module preamble_postamble_deframer_unit #(
   parameter int MAX_FRAME_LEN = ppd_pkg::MAX_FRAME_LEN_DEF,
   parameter int MARKER_LEN    = ppd_pkg::MARKER_LEN_DEF
) (
   input  logic     clock,
   input  logic     reset,
   ppd_req_if.sink  req_if,
   ppd_rsp_if.source rsp_if,
   ppd_csr_if.sink  csr_if
);
   import ppd_pkg::*;

   cfg_type cfg;

   // input word register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_eof_ff, in_eof_in;

   // output word register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic    step_en;
   logic    has_result;
   rsp_type result;
   logic    out_free;
   logic    req_take;

   // register file, writes accepted every cycle
   assign csr_if.ready = 1'b1;

   ppd_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .cfg      (cfg)
   );

   // output slot frees up when empty or drained this cycle
   assign out_free = !out_valid_ff || rsp_if.ready;

   // a byte with no result never waits on the output side
   assign step_en = in_valid_ff && (out_free || !has_result);

   ppd_parser #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN),
      .MARKER_LEN    (MARKER_LEN)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step_en      (step_en),
      .rx_byte      (in_byte_ff),
      .end_of_frame (in_eof_ff),
      .has_result   (has_result),
      .result       (result)
   );

   // input register refills as soon as its word moves into the parser
   assign req_if.ready = !in_valid_ff || step_en;
   assign req_take     = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eof_in   = in_eof_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.rx_byte;
         in_eof_in   = req_if.end_of_frame;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step_en && has_result) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eof_ff  <= in_eof_in;
      out_ff     <= out_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.item_type    = out_ff.item_type;
   assign rsp_if.payload_byte = out_ff.payload_byte;
   assign rsp_if.accepted     = out_ff.accepted;
   assign rsp_if.message_len  = out_ff.message_len;
   assign rsp_if.last         = out_ff.last;

endmodule
